@@ design/sca_pkg.sv @@
// Package for the sound channel allocator: field widths, constants, codes and types.
// Used by sca_div, sca_chan and sound_channel_allocator. No dependencies.
package sca_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int CH_IDX_W         = 4;    // channel index in status, covers up to 16

    localparam int ACTION_W   = 2;
    localparam int RATE_W     = 15;
    localparam int LEN_W      = 17;
    localparam int VOL_W      = 7;
    localparam int PRIO_W     = 8;
    localparam int ID_W       = 8;
    localparam int CHAN_W     = 2;
    localparam int DUR_W      = 15;
    localparam int PERIOD_W   = 12;
    localparam int WORDS_W    = 16;
    localparam int MASK_W     = 4;
    localparam int COUNT_W    = 3;
    localparam int FPS_W      = 8;
    localparam int CFG_DATA_W = 8;

    // len * fps + rate - 1 stays below 2^25
    localparam int DIV_W = 25;

    localparam logic [DIV_W-1:0]    AUDIO_CLOCK  = 25'd3546895;
    localparam logic [PERIOD_W-1:0] PERIOD_FLOOR = 12'd124;
    localparam logic [PERIOD_W-1:0] PERIOD_CEIL  = 12'd4095;
    localparam logic [DUR_W-1:0]    TICKS_MAX    = 15'd32767;
    localparam logic [VOL_W-1:0]    VOLUME_MAX   = 7'd64;
    localparam logic [WORDS_W-1:0]  WORDS_MAX    = 16'hFFFF;

    localparam logic [FPS_W-1:0] FRAME_RATE_RST    = 8'd50;
    localparam logic [VOL_W-1:0] MASTER_VOLUME_RST = 7'd64;

    typedef enum logic [0:0] {
        CFG_FRAME_RATE    = 1'b0,
        CFG_MASTER_VOLUME = 1'b1
    } t_cfg_index;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PLAY     = 2'd0,
        ACT_TICK     = 2'd1,
        ACT_STOP_ALL = 2'd2,
        ACT_RELEASE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_DUR,
        S_DIV_PER,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              apply;
        t_action           action;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
        logic [DUR_W-1:0]  dur;
    } t_chan_cmd;

    typedef struct packed {
        logic                pick_ok;
        logic [CH_IDX_W-1:0] pick;
        logic [MASK_W-1:0]   stopped;
        logic [COUNT_W-1:0]  count;
    } t_chan_stat;

endpackage

@@ design/sca_div.sv @@
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on sca_pkg for the dividend and divisor widths.
module sca_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sca_pkg::DIV_W-1:0]  i_dividend,
    input  logic [sca_pkg::RATE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [sca_pkg::DIV_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(sca_pkg::DIV_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [sca_pkg::RATE_W-1:0] r_rem;
    logic [sca_pkg::RATE_W-1:0] r_div;
    logic [sca_pkg::DIV_W-1:0]  r_quo;

    logic [sca_pkg::RATE_W:0]   w_trial;
    logic                       w_fits;
    logic [sca_pkg::RATE_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[sca_pkg::DIV_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(sca_pkg::DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[sca_pkg::RATE_W-1:0] : w_trial[sca_pkg::RATE_W-1:0];
            r_quo <= {r_quo[sca_pkg::DIV_W-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ design/sca_chan.sv @@
// Channel table: per-channel state, channel pick for play requests, tick and release.
// Depends on sca_pkg for command and status structs.
module sca_chan #(
    parameter int NUM_CHANNELS = sca_pkg::NUM_CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sca_pkg::t_chan_cmd  i_cmd,
    output sca_pkg::t_chan_stat o_stat
);

    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W  = (NUM_CHANNELS > sca_pkg::MASK_W) ? NUM_CHANNELS : sca_pkg::MASK_W;
    localparam int SUM_W  = $clog2(NUM_CHANNELS + 1) + 1;

    logic [NUM_CHANNELS-1:0]       r_active;
    logic [sca_pkg::PRIO_W-1:0]    r_prio   [NUM_CHANNELS];
    logic [sca_pkg::DUR_W-1:0]     r_remain [NUM_CHANNELS];
    logic [sca_pkg::ID_W-1:0]      r_sound  [NUM_CHANNELS];

    logic [NUM_CHANNELS-1:0]       n_active;
    logic [sca_pkg::DUR_W-1:0]     n_remain [NUM_CHANNELS];

    logic                          w_free_found;
    logic [IDX_W-1:0]              w_free_idx;
    logic                          w_steal_found;
    logic [IDX_W-1:0]              w_steal_idx;
    logic                          w_pick_ok;
    logic [IDX_W-1:0]              w_pick;
    logic [NUM_CHANNELS-1:0]       w_stop;
    logic [NUM_CHANNELS-1:0]       w_take;
    logic [EXT_W-1:0]              w_stop_ext;
    logic [SUM_W-1:0]              w_cnt;

    // lowest idle channel, else lowest channel the request may override
    always_comb begin
        w_free_found  = 1'b0;
        w_free_idx    = '0;
        w_steal_found = 1'b0;
        w_steal_idx   = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IDX_W'(i);
            end
            if (i_cmd.prio >= r_prio[i]) begin
                w_steal_found = 1'b1;
                w_steal_idx   = IDX_W'(i);
            end
        end
        w_pick_ok = w_free_found | w_steal_found;
        w_pick    = w_free_found ? w_free_idx : w_steal_idx;
    end

    always_comb begin
        w_stop = '0;
        w_take = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            n_remain[i] = r_remain[i];
        end
        unique case (i_cmd.action)
            sca_pkg::ACT_PLAY: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    w_take[i] = w_pick_ok && (w_pick == IDX_W'(i));
                    if (w_take[i]) begin
                        n_remain[i] = i_cmd.dur;
                    end
                end
            end
            sca_pkg::ACT_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (r_active[i]) begin
                        if (r_remain[i] <= sca_pkg::DUR_W'(1)) begin
                            w_stop[i] = 1'b1;
                        end else begin
                            n_remain[i] = r_remain[i] - sca_pkg::DUR_W'(1);
                        end
                    end
                end
            end
            sca_pkg::ACT_STOP_ALL: begin
                w_stop = r_active;
            end
            sca_pkg::ACT_RELEASE: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    w_stop[i] = r_active[i] && (r_sound[i] == i_cmd.id);
                end
            end
            default: begin
                w_stop = '0;
            end
        endcase
        n_active = (r_active & ~w_stop) | w_take;
    end

    always_comb begin
        w_cnt = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            w_cnt = w_cnt + SUM_W'(n_active[i]);
        end
    end

    assign w_stop_ext = EXT_W'(w_stop);

    always_comb begin
        o_stat.pick_ok = w_pick_ok;
        o_stat.pick    = sca_pkg::CH_IDX_W'(w_pick);
        o_stat.stopped = w_stop_ext[sca_pkg::MASK_W-1:0];
        o_stat.count   = (w_cnt > SUM_W'(7)) ? sca_pkg::COUNT_W'(7)
                                             : sca_pkg::COUNT_W'(w_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.apply) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_prio[i]   <= '0;
                r_remain[i] <= '0;
                r_sound[i]  <= '0;
            end
        end else if (i_cmd.apply) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_remain[i] <= n_remain[i];
                if (w_take[i]) begin
                    r_prio[i]  <= i_cmd.prio;
                    r_sound[i] <= i_cmd.id;
                end
            end
        end
    end

endmodule

@@ design/sound_channel_allocator.sv @@
// Sound channel allocator top: sequencer, config registers, result register.
// Depends on sca_pkg, sca_div and sca_chan.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   action, rate, length, volume, priority, id
//   out      output     o_out_valid / i_out_ready granted .. active_count
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// Play request: after the transfer, a setup state starts the shared 25-step divider for
// the duration; its second pass gives the period, and the done state writes the result
// once the output register is free.
// Tick, stop-all and release go from idle straight to the done state.
// One transfer in flight; o_in_ready is high only in idle.
// A finished result waits in the output register while the next item is taken; the
// next result holds in the done state until the output register is free.
// Reset is synchronous, active low; channels come up free, frame rate 50, volume 64.
module sound_channel_allocator #(
    parameter int NUM_CHANNELS = sca_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_index,
    input  logic [sca_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sca_pkg::ACTION_W-1:0]   i_action,
    input  logic [sca_pkg::RATE_W-1:0]     i_sample_rate,
    input  logic [sca_pkg::LEN_W-1:0]      i_sample_length,
    input  logic [sca_pkg::VOL_W-1:0]      i_sound_volume,
    input  logic [sca_pkg::PRIO_W-1:0]     i_sound_priority,
    input  logic [sca_pkg::ID_W-1:0]       i_sound_id,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_granted,
    output logic [sca_pkg::CHAN_W-1:0]     o_channel,
    output logic [sca_pkg::DUR_W-1:0]      o_duration_ticks,
    output logic [sca_pkg::PERIOD_W-1:0]   o_period,
    output logic [sca_pkg::VOL_W-1:0]      o_hw_volume,
    output logic [sca_pkg::WORDS_W-1:0]    o_sample_words,
    output logic [sca_pkg::MASK_W-1:0]     o_stopped_mask,
    output logic [sca_pkg::COUNT_W-1:0]    o_active_count
);

    localparam int DIV_W = sca_pkg::DIV_W;
    localparam int PROD_W = 2 * sca_pkg::VOL_W - 1;

    sca_pkg::t_state r_state, n_state;

    logic [sca_pkg::FPS_W-1:0]   r_frame_rate;
    logic [sca_pkg::VOL_W-1:0]   r_master_vol;

    sca_pkg::t_action            r_action;
    logic [sca_pkg::RATE_W-1:0]  r_rate;
    logic [sca_pkg::LEN_W-1:0]   r_len;
    logic [sca_pkg::VOL_W-1:0]   r_vol;
    logic [sca_pkg::PRIO_W-1:0]  r_prio;
    logic [sca_pkg::ID_W-1:0]    r_id;
    logic [sca_pkg::DUR_W-1:0]   r_dur, n_dur;
    logic [sca_pkg::PERIOD_W-1:0] r_period, n_period;

    logic                        w_in_xfer;
    logic                        w_out_free;
    logic                        w_apply;
    logic                        w_div_start;
    logic [DIV_W-1:0]            w_div_dividend;
    logic                        w_div_done;
    logic [DIV_W-1:0]            w_quo;
    logic [DIV_W-1:0]            w_prod;
    logic [DIV_W-1:0]            w_dur_num;
    logic [sca_pkg::VOL_W-1:0]   w_sv;
    logic [sca_pkg::VOL_W-1:0]   w_mv;
    logic [PROD_W-1:0]           w_vol_prod;
    logic [PROD_W-1:0]           w_vol_rnd;
    logic [sca_pkg::LEN_W:0]     w_alloc;
    logic [sca_pkg::LEN_W-1:0]   w_half;
    logic [sca_pkg::WORDS_W-1:0] w_words;
    logic                        w_play;
    logic                        w_grant;

    sca_pkg::t_chan_cmd          w_cmd;
    sca_pkg::t_chan_stat         w_stat;

    sca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_rate),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    sca_chan #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= sca_pkg::FRAME_RATE_RST;
            r_master_vol <= sca_pkg::MASTER_VOLUME_RST;
        end else if (i_cfg_we) begin
            unique case (sca_pkg::t_cfg_index'(i_cfg_index))
                sca_pkg::CFG_FRAME_RATE:    r_frame_rate <= i_cfg_data;
                sca_pkg::CFG_MASTER_VOLUME: r_master_vol <= i_cfg_data[sca_pkg::VOL_W-1:0];
                default:                    r_frame_rate <= r_frame_rate;
            endcase
        end
    end

    assign o_in_ready = (r_state == sca_pkg::S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    // ceil(len * fps / rate) numerator
    assign w_prod    = DIV_W'(r_len) * DIV_W'(r_frame_rate);
    assign w_dur_num = w_prod + DIV_W'(r_rate) - DIV_W'(1);

    always_comb begin
        if (w_quo > DIV_W'(sca_pkg::PERIOD_CEIL)) begin
            n_period = sca_pkg::PERIOD_CEIL;
        end else if (w_quo < DIV_W'(sca_pkg::PERIOD_FLOOR)) begin
            n_period = sca_pkg::PERIOD_FLOOR;
        end else begin
            n_period = w_quo[sca_pkg::PERIOD_W-1:0];
        end
        if (r_rate == '0) begin
            n_period = sca_pkg::PERIOD_CEIL;
        end

        if (r_rate == '0 || r_frame_rate == '0 || w_quo == '0) begin
            n_dur = sca_pkg::DUR_W'(1);
        end else if (w_quo > DIV_W'(sca_pkg::TICKS_MAX)) begin
            n_dur = sca_pkg::TICKS_MAX;
        end else begin
            n_dur = w_quo[sca_pkg::DUR_W-1:0];
        end
    end

    always_comb begin
        n_state        = r_state;
        w_div_start    = 1'b0;
        w_div_dividend = w_dur_num;
        w_apply        = 1'b0;
        unique case (r_state)
            sca_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (sca_pkg::t_action'(i_action) == sca_pkg::ACT_PLAY)
                              ? sca_pkg::S_MUL : sca_pkg::S_DONE;
                end
            end
            sca_pkg::S_MUL: begin
                w_div_start = 1'b1;
                n_state     = sca_pkg::S_DIV_DUR;
            end
            sca_pkg::S_DIV_DUR: begin
                if (w_div_done) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = sca_pkg::AUDIO_CLOCK;
                    n_state        = sca_pkg::S_DIV_PER;
                end
            end
            sca_pkg::S_DIV_PER: begin
                if (w_div_done) begin
                    n_state = sca_pkg::S_DONE;
                end
            end
            sca_pkg::S_DONE: begin
                if (w_out_free) begin
                    w_apply = 1'b1;
                    n_state = sca_pkg::S_IDLE;
                end
            end
            default: n_state = sca_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_action <= sca_pkg::t_action'(i_action);
            r_rate   <= i_sample_rate;
            r_len    <= i_sample_length;
            r_vol    <= i_sound_volume;
            r_prio   <= i_sound_priority;
            r_id     <= i_sound_id;
        end
        if (r_state == sca_pkg::S_DIV_DUR && w_div_done) begin
            r_dur <= n_dur;
        end
        if (r_state == sca_pkg::S_DIV_PER && w_div_done) begin
            r_period <= n_period;
        end
    end

    assign w_cmd = {w_apply, r_action, r_prio, r_id, r_dur};

    assign w_sv       = (r_vol > sca_pkg::VOLUME_MAX) ? sca_pkg::VOLUME_MAX : r_vol;
    assign w_mv       = (r_master_vol > sca_pkg::VOLUME_MAX) ? sca_pkg::VOLUME_MAX
                                                             : r_master_vol;
    assign w_vol_prod = PROD_W'(w_sv) * PROD_W'(w_mv);
    assign w_vol_rnd  = w_vol_prod + PROD_W'(sca_pkg::VOLUME_MAX >> 1);

    assign w_alloc = {1'b0, r_len} + (sca_pkg::LEN_W + 1)'(r_len[0]);
    assign w_half  = w_alloc[sca_pkg::LEN_W:1];
    assign w_words = (w_half > sca_pkg::LEN_W'(sca_pkg::WORDS_MAX)) ? sca_pkg::WORDS_MAX
                                                                  : w_half[sca_pkg::WORDS_W-1:0];

    assign w_play  = (r_action == sca_pkg::ACT_PLAY);
    assign w_grant = w_play && w_stat.pick_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_apply) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            o_granted        <= w_grant;
            o_channel        <= w_grant ? w_stat.pick[sca_pkg::CHAN_W-1:0] : '0;
            o_duration_ticks <= w_grant ? r_dur : '0;
            o_period         <= w_grant ? r_period : '0;
            o_hw_volume      <= w_grant ? w_vol_rnd[PROD_W-1:PROD_W-sca_pkg::VOL_W] : '0;
            o_sample_words   <= w_grant ? w_words : '0;
            o_stopped_mask   <= w_play ? '0 : w_stat.stopped;
            o_active_count   <= w_stat.count;
        end
    end

    ap_div_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == sca_pkg::S_DIV_DUR || r_state == sca_pkg::S_DIV_PER))
        else $error("divider finished outside a division step");

    ap_grant_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted |-> o_duration_ticks != '0 &&
            o_period >= sca_pkg::PERIOD_FLOOR && o_active_count != '0)
        else $error("granted result with bad duration, period or count");

    ap_grant_no_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted |-> o_stopped_mask == '0)
        else $error("play result reports freed channels");

    ap_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply |-> w_out_free)
        else $error("result written over a pending transfer");

endmodule
